### sv/rle_pixel_word_encoder_assert.svh
// Assertion macros used by the checker file.
`ifndef RLE_PIXEL_WORD_ENCODER_ASSERT_SVH
`define RLE_PIXEL_WORD_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RPWE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RPWE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rpwe_pkg.sv
`timescale 1ns / 1ps
package rpwe_pkg;

  localparam logic [7:0] RUN_LIMIT = 8'd255;

  // Result queue: two slots per item plus slack so one item per cycle flows while rec is not stalled.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       end_of_stream;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] run_length;
    logic [7:0] run_first_byte;
    logic [7:0] run_second_byte;
    logic       final_record;
  } rec_item_t;

  typedef struct packed {
    logic first_valid;
    logic second_valid;
  } rec_push_t;

endpackage

### sv/rpwe_tracker.sv
`timescale 1ns / 1ps
module rpwe_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  rpwe_pkg::pix_item_t pix,
  output rpwe_pkg::rec_push_t push,
  output rpwe_pkg::rec_item_t rec0,
  output rpwe_pkg::rec_item_t rec1
);

  logic [7:0] held_first;
  logic [7:0] held_second;
  logic [7:0] run_count;
  logic       run_open;

  logic       close_run;
  logic       restart;
  logic [7:0] held_first_next;
  logic [7:0] held_second_next;
  logic [7:0] count_next;
  rpwe_pkg::rec_item_t closed_rec;
  rpwe_pkg::rec_item_t flush_rec;

  assign close_run = run_open && (run_count == rpwe_pkg::RUN_LIMIT ||
                                  pix.first_byte != held_first ||
                                  pix.second_byte != held_second);
  assign restart = !run_open || close_run;

  assign held_first_next  = restart ? pix.first_byte  : held_first;
  assign held_second_next = restart ? pix.second_byte : held_second;
  assign count_next       = restart ? 8'd1 : run_count + 8'd1;

  assign closed_rec = '{run_length: run_count, run_first_byte: held_first,
                        run_second_byte: held_second, final_record: 1'b0};
  assign flush_rec  = '{run_length: count_next, run_first_byte: held_first_next,
                        run_second_byte: held_second_next, final_record: 1'b1};

  // Pack records into the lowest slots: a closed run always goes ahead of the flush.
  always_comb begin
    push.first_valid  = accept && (close_run || pix.end_of_stream);
    push.second_valid = accept && close_run && pix.end_of_stream;
    rec0 = close_run ? closed_rec : flush_rec;
    rec1 = flush_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_first  <= 8'd0;
      held_second <= 8'd0;
      run_count   <= 8'd0;
      run_open    <= 1'b0;
    end else if (accept) begin
      held_first  <= held_first_next;
      held_second <= held_second_next;
      if (pix.end_of_stream) begin
        run_count <= 8'd0;
        run_open  <= 1'b0;
      end else begin
        run_count <= count_next;
        run_open  <= 1'b1;
      end
    end
  end

endmodule

### sv/rpwe_queue.sv
`timescale 1ns / 1ps
module rpwe_queue (
  input  logic               clk,
  input  logic               rst,
  input  rpwe_pkg::rec_push_t push,
  input  rpwe_pkg::rec_item_t rec0,
  input  rpwe_pkg::rec_item_t rec1,
  output logic               room_low,
  output logic               rec_valid,
  input  logic               rec_stall,
  output rpwe_pkg::rec_item_t rec
);

  rpwe_pkg::rec_item_t mem [rpwe_pkg::QUEUE_DEPTH];

  logic [rpwe_pkg::QPTR_W-1:0] wr_ptr;
  logic [rpwe_pkg::QPTR_W-1:0] rd_ptr;
  logic [rpwe_pkg::QCNT_W-1:0] count;
  logic [rpwe_pkg::QCNT_W-1:0] push_n;
  logic                        pop;

  assign push_n = rpwe_pkg::QCNT_W'(push.first_valid) +
                  rpwe_pkg::QCNT_W'(push.second_valid);
  assign pop    = rec_valid && !rec_stall;

  assign rec_valid = count != '0;
  assign rec       = mem[rd_ptr];
  // Hold off input unless two slots are free.
  assign room_low  = count > rpwe_pkg::QCNT_W'(rpwe_pkg::QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      mem[wr_ptr] <= rec0;
    end
    if (push.second_valid) begin
      mem[wr_ptr + rpwe_pkg::QPTR_W'(1)] <= rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[rpwe_pkg::QPTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + rpwe_pkg::QPTR_W'(1);
      end
      count <= count + push_n - rpwe_pkg::QCNT_W'(pop);
    end
  end

endmodule

### sv/rle_pixel_word_encoder.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// pix      in         pix_valid / pix_stall  first_byte, second_byte, end_of_stream
// rec      out        rec_valid / rec_stall  run_length, run bytes, final_record
//
// One pixel word is taken per cycle while pix_stall is low; its records enter a four-slot queue
// at the same edge and are offered on rec from the queue head in order.
// A word gives zero, one or two records; rec drains one per cycle while rec_stall is low.
// pix_stall rises when fewer than two queue slots are free (three or more records
// waiting), so a stalled rec side backs up into pix after at most three record-giving words.
// rst (synchronous) closes any open run and empties the queue.
module rle_pixel_word_encoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  output logic                pix_stall,
  input  rpwe_pkg::pix_item_t pix,
  output logic                rec_valid,
  input  logic                rec_stall,
  output rpwe_pkg::rec_item_t rec
);

  logic                accept;
  rpwe_pkg::rec_push_t push;
  rpwe_pkg::rec_item_t rec0;
  rpwe_pkg::rec_item_t rec1;

  assign accept = pix_valid && !pix_stall;

  rpwe_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .pix    (pix),
    .push   (push),
    .rec0   (rec0),
    .rec1   (rec1)
  );

  rpwe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rec0      (rec0),
    .rec1      (rec1),
    .room_low  (pix_stall),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec       (rec)
  );

endmodule

### sv/rpwe_checker.sv
`timescale 1ns / 1ps
`include "rle_pixel_word_encoder_assert.svh"
module rpwe_checker (
  input logic                clk,
  input logic                rst,
  input logic                pix_valid,
  input logic                pix_stall,
  input rpwe_pkg::pix_item_t pix,
  input logic                rec_valid,
  input logic                rec_stall,
  input rpwe_pkg::rec_item_t rec
);

  `RPWE_ASSERT_NEXT(a_rec_hold, rec_valid && rec_stall, rec_valid && $stable(rec), "rec item changed while stalled")
  `RPWE_ASSERT_NOW(a_len_nonzero, rec_valid, rec.run_length != 8'd0, "record with zero run length")
  `RPWE_ASSERT_NOW(a_empty_no_stall, !rec_valid, !pix_stall, "input stalled with no record pending")
  `RPWE_ASSERT_NEXT(a_eos_flush, !rec_valid && pix_valid && !pix_stall && pix.end_of_stream, rec_valid, "end of stream gave no record")

endmodule

bind rle_pixel_word_encoder rpwe_checker u_rpwe_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix_valid),
  .pix_stall (pix_stall),
  .pix       (pix),
  .rec_valid (rec_valid),
  .rec_stall (rec_stall),
  .rec       (rec)
);
